// ===== design/lfu_pkg.sv =====
// Shared types and constants for the block use-count tracker.
// No dependencies; used by every module of the tracker.
package lfu_pkg;

  localparam int unsigned TableEntries = 256;
  localparam int unsigned CountLimit   = 255;
  localparam int unsigned IdxW         = $clog2(TableEntries);
  localparam int unsigned FillW        = $clog2(TableEntries + 1);
  localparam int unsigned CntW         = 8;
  localparam int unsigned BktW         = $clog2(CountLimit + 1);
  localparam int unsigned AddrW        = 64;
  localparam int unsigned TotW         = 32;
  localparam int unsigned OutW         = 120;

  typedef enum logic {
    OP_ACTIVATE = 1'b0,
    OP_ACCESS   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    MOVE_NONE    = 2'd0,
    MOVE_TO_HEAD = 2'd1,
    MOVE_TO_TAIL = 2'd2
  } move_e;

  typedef struct packed {
    op_e              op;
    logic [AddrW-1:0] addr;
  } item_t;

  typedef struct packed {
    move_e            move;
    logic [CntW-1:0]  use_count;
    logic [CntW-1:0]  lowest_count;
    logic [AddrW-1:0] victim;
    logic             failed;
    logic [TotW-1:0]  activations;
  } result_t;

endpackage

// ===== design/lfu_front.sv =====
// Input side of the tracker: accepts items and holds them in a two-entry queue.
// Depends on lfu_pkg.
module lfu_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [63:0]       s_axis_tdata,
  input  logic              s_axis_tuser,
  output logic              q_valid_o,
  output lfu_pkg::item_t    q_item_o,
  input  logic              q_pop_i
);

  lfu_pkg::item_t slot_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           push, pop;

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid_o     = (cnt_q != 2'd0);
  assign pop           = q_pop_i && q_valid_o;
  assign q_item_o      = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= '{op: lfu_pkg::op_e'(s_axis_tuser), addr: s_axis_tdata};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== design/lfu_back.sv =====
// Execution side of the tracker: entry scan, count and bucket updates, result register.
// Depends on lfu_pkg.
module lfu_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  lfu_pkg::item_t    q_item_i,
  output logic              q_pop_o,
  output logic              res_valid_o,
  output lfu_pkg::result_t  res_o,
  input  logic              res_ready_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_CMP, S_DEC, S_OLD_RD, S_UPD, S_FL_RD, S_FIN
  } state_e;

  localparam logic [lfu_pkg::CntW-1:0] Limit = lfu_pkg::CntW'(lfu_pkg::CountLimit);
  localparam logic [lfu_pkg::CntW-1:0] One   = lfu_pkg::CntW'(1);

  logic [lfu_pkg::AddrW-1:0] tag_mem [lfu_pkg::TableEntries];
  logic [lfu_pkg::CntW-1:0]  cnt_mem [lfu_pkg::TableEntries];
  logic [lfu_pkg::AddrW-1:0] bkt_mem [lfu_pkg::CountLimit+1];
  logic [lfu_pkg::CountLimit:0] bkt_vld_q;

  state_e                    state_q;
  lfu_pkg::item_t            item_q;
  logic [lfu_pkg::FillW-1:0] fill_q;
  logic [lfu_pkg::IdxW-1:0]  idx_q;
  logic [lfu_pkg::AddrW-1:0] tag_rd_q, bkt_rd_q;
  logic [lfu_pkg::CntW-1:0]  cnt_rd_q, old_q, new_q, floor_q;
  logic                      bkt_rv_q, hit_q, out_valid_q;
  logic [lfu_pkg::TotW-1:0]  total_q;
  lfu_pkg::result_t          res_q;

  logic [lfu_pkg::BktW-1:0]  bkt_ra;
  logic [lfu_pkg::CntW-1:0]  old_c;
  logic [lfu_pkg::AddrW-1:0] holder;
  logic                      start, act, full, cleared, empty_after;

  assign start   = (state_q == S_IDLE) && q_valid_i && !out_valid_q;
  assign q_pop_o = start;
  assign act     = (item_q.op == lfu_pkg::OP_ACTIVATE);
  assign full    = (fill_q == lfu_pkg::FillW'(lfu_pkg::TableEntries));
  assign bkt_ra  = (state_q == S_OLD_RD) ? lfu_pkg::BktW'(old_q) : lfu_pkg::BktW'(floor_q);
  assign old_c   = (cnt_rd_q == '0) ? One : ((cnt_rd_q > Limit) ? Limit : cnt_rd_q);
  assign holder  = bkt_rv_q ? bkt_rd_q : '0;
  assign cleared = (holder == item_q.addr);
  assign empty_after = (new_q == old_q) ? (item_q.addr == '0) : (cleared || holder == '0);
  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i) begin
    tag_rd_q <= tag_mem[idx_q];
    cnt_rd_q <= cnt_mem[idx_q];
    bkt_rd_q <= bkt_mem[bkt_ra];
    bkt_rv_q <= bkt_vld_q[bkt_ra];
    if (state_q == S_DEC && act) begin
      bkt_mem[1] <= item_q.addr;
      if (hit_q) begin
        cnt_mem[idx_q] <= One;
      end else if (!full) begin
        tag_mem[fill_q[lfu_pkg::IdxW-1:0]] <= item_q.addr;
        cnt_mem[fill_q[lfu_pkg::IdxW-1:0]] <= One;
      end
    end
    if (state_q == S_UPD) begin
      bkt_mem[lfu_pkg::BktW'(new_q)] <= item_q.addr;
      cnt_mem[idx_q]                 <= new_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      idx_q       <= '0;
      hit_q       <= 1'b0;
      floor_q     <= One;
      total_q     <= '0;
      bkt_vld_q   <= '0;
      out_valid_q <= 1'b0;
      item_q      <= '0;
      old_q       <= '0;
      new_q       <= '0;
      res_q       <= '0;
    end else begin
      if (out_valid_q && res_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            item_q  <= q_item_i;
            idx_q   <= '0;
            hit_q   <= 1'b0;
            state_q <= (fill_q == '0) ? S_DEC : S_RD;
          end
        end
        S_RD: state_q <= S_CMP;
        S_CMP: begin
          if (tag_rd_q == item_q.addr) begin
            hit_q   <= 1'b1;
            old_q   <= old_c;
            new_q   <= (old_c == Limit) ? Limit : old_c + One;
            state_q <= S_DEC;
          end else if (lfu_pkg::FillW'(idx_q) + 1'b1 == fill_q) begin
            state_q <= S_DEC;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_RD;
          end
        end
        S_DEC: begin
          if (act) begin
            if (!hit_q && !full) fill_q <= fill_q + 1'b1;
            bkt_vld_q[1]       <= 1'b1;
            floor_q            <= One;
            if (total_q != '1) total_q <= total_q + 1'b1;
            res_q.activations  <= (total_q != '1) ? total_q + 1'b1 : total_q;
            res_q.move         <= lfu_pkg::MOVE_TO_HEAD;
            res_q.use_count    <= (hit_q || !full) ? One : '0;
            res_q.failed       <= !hit_q && full;
            res_q.lowest_count <= One;
            res_q.victim       <= item_q.addr;
            out_valid_q        <= 1'b1;
            state_q            <= S_IDLE;
          end else if (hit_q) begin
            res_q.failed <= 1'b0;
            state_q      <= S_OLD_RD;
          end else begin
            res_q.failed    <= 1'b0;
            res_q.move      <= lfu_pkg::MOVE_NONE;
            res_q.use_count <= '0;
            state_q         <= S_FL_RD;
          end
        end
        S_OLD_RD: state_q <= S_UPD;
        S_UPD: begin
          if (cleared && new_q != old_q) bkt_vld_q[lfu_pkg::BktW'(old_q)] <= 1'b0;
          bkt_vld_q[lfu_pkg::BktW'(new_q)] <= 1'b1;
          if (old_q == floor_q && empty_after) floor_q <= new_q;
          res_q.move      <= (new_q > old_q) ? lfu_pkg::MOVE_TO_TAIL : lfu_pkg::MOVE_NONE;
          res_q.use_count <= new_q;
          state_q         <= S_FL_RD;
        end
        S_FL_RD: state_q <= S_FIN;
        S_FIN: begin
          res_q.lowest_count <= floor_q;
          res_q.victim       <= holder;
          res_q.activations  <= total_q;
          out_valid_q        <= 1'b1;
          state_q            <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/lfu_block_tracker.sv =====
// Top level of the block use-count tracker: queue front end and execution back end.
// Depends on lfu_pkg, lfu_front and lfu_back.
//
// One item at a time is carried out. An item takes a tag memory read, then a
// compare, per table entry scanned until its tag matches or all filled entries
// are passed. An activate then finishes; an access goes on to a bucket store
// read, update and floor read for a known block, else the floor read alone.
// Up to two items wait in the input queue while a result is held.
module lfu_block_tracker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [63:0]   s_axis_tdata,  // block_address
  input  logic          s_axis_tuser,  // operation
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [119:0]  m_axis_tdata   // list_move, use_count, lowest_count,
                                       // victim_address, insert_failed, activations
);

  logic             q_valid, q_pop;
  lfu_pkg::item_t   q_item;
  lfu_pkg::result_t res;

  lfu_front u_front (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  lfu_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .res_valid_o(m_axis_tvalid), .res_o(res), .res_ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {5'd0, res.activations, res.failed, res.victim,
                         res.lowest_count, res.use_count, res.move};

endmodule
